>>> src/pqs_pkg.sv
// shared types and constants for the priority queue server
// no dependencies
package pqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int NUM_CLASSES_DEF = 4;

   typedef enum logic [1:0] {
      CMD_BEGIN_TICK = 2'd0,
      CMD_ARRIVE     = 2'd1,
      CMD_END_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      EV_HANG_UP   = 3'd0,
      EV_ANSWERED  = 3'd1,
      EV_COMPLETED = 3'd2,
      EV_ACCEPTED  = 3'd3,
      EV_REJECTED  = 3'd4
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SERVE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_ARRIVE,
      ST_ANS_RD,
      ST_ANSWER,
      ST_AGE_RD,
      ST_AGE_WR,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] patience;
      logic [15:0] duration;
   } entry_type;

   typedef struct packed {
      logic latch;
      logic srv_tick;
      logic keep;
      logic drop;
      logic cls_end;
      logic arrive;
      logic pick;
      logic answer;
      logic age_start;
      logic age_wr;
      logic age_next;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       busy;
      logic       any_nonempty;
      logic       k_done;
      logic       last_cls;
      logic       pat_zero;
      logic       emit_ok;
      logic       out_free;
      logic       pend_valid;
   } ctl_status_type;

endpackage

>>> src/pqs_if.sv
// request and response channel interfaces
// depends on nothing but the handshake convention valid/ready
interface pqs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] caller_id;
   logic [1:0]  priority_class;
   logic [15:0] patience;
   logic [15:0] service_ticks;

   modport source (output valid, command, caller_id, priority_class, patience,
                   service_ticks, input ready);
   modport sink (input valid, command, caller_id, priority_class, patience,
                 service_ticks, output ready);
endinterface

interface pqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [15:0] event_id;
   logic [1:0]  event_class;
   logic        last;

   modport source (output valid, event_res, event_id, event_class, last, input ready);
   modport sink (input valid, event_res, event_id, event_class, last, output ready);
endinterface

>>> src/pqs_ctrl.sv
// controller state machine: sequences ticks, arrivals and queue walks
// depends on pqs_pkg
module pqs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pqs_pkg::ctl_status_type status,
   output pqs_pkg::ctl_cmd_type    cmd
);
   import pqs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.cmd)
               CMD_BEGIN_TICK: state_in = ST_SERVE;
               CMD_ARRIVE:     state_in = ST_ARRIVE;
               CMD_END_TICK: begin
                  if (!status.busy && status.any_nonempty) state_in = ST_ANS_RD;
                  else state_in = ST_AGE_RD;
               end
               default:        state_in = ST_FLUSH;
            endcase
         end
         ST_SERVE: begin
            if (status.emit_ok) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (!status.k_done) state_in = ST_SCAN_CHK;
            else if (status.last_cls) state_in = ST_FLUSH;
         end
         ST_SCAN_CHK: begin
            if (!status.pat_zero || status.emit_ok) state_in = ST_SCAN_RD;
         end
         ST_ARRIVE: begin
            if (status.emit_ok) state_in = ST_FLUSH;
         end
         ST_ANS_RD: state_in = ST_ANSWER;
         ST_ANSWER: begin
            if (status.emit_ok) state_in = ST_AGE_RD;
         end
         ST_AGE_RD: begin
            if (!status.k_done) state_in = ST_AGE_WR;
            else if (status.last_cls) state_in = ST_FLUSH;
         end
         ST_AGE_WR: state_in = ST_AGE_RD;
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         ST_DECODE: begin
            if (status.cmd == CMD_END_TICK) begin
               if (!status.busy && status.any_nonempty) cmd.pick = 1'b1;
               else cmd.age_start = 1'b1;
            end
         end
         ST_SERVE:    cmd.srv_tick = status.emit_ok;
         ST_SCAN_RD:  cmd.cls_end = status.k_done;
         ST_SCAN_CHK: begin
            if (status.pat_zero) cmd.drop = status.emit_ok;
            else cmd.keep = 1'b1;
         end
         ST_ARRIVE:   cmd.arrive = status.emit_ok;
         ST_ANSWER:   cmd.answer = status.emit_ok;
         ST_AGE_RD:   cmd.age_next = status.k_done && !status.last_cls;
         ST_AGE_WR:   cmd.age_wr = 1'b1;
         ST_FLUSH:    cmd.flush = status.pend_valid && status.out_free;
         default: ;
      endcase
   end

   a_one_walk_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.keep, cmd.drop, cmd.age_wr, cmd.arrive, cmd.answer}) <= 1)
      else $error("conflicting datapath commands");
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && state_in == ST_IDLE) |=> !status.pend_valid)
      else $error("pending event left after item end");
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> state_ff == ST_DECODE)
      else $error("item latched outside idle");

endmodule

>>> src/pqs_dp.sv
// datapath: queue memory, heads/counts, server, event staging and output register
// depends on pqs_pkg and pqs_rsp_if
module pqs_dp #(
   parameter int QUEUE_DEPTH = pqs_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_CLASSES = pqs_pkg::NUM_CLASSES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_command,
   input  logic [15:0]             req_caller_id,
   input  logic [1:0]              req_priority_class,
   input  logic [15:0]             req_patience,
   input  logic [15:0]             req_service_ticks,
   input  pqs_pkg::ctl_cmd_type    cmd,
   output pqs_pkg::ctl_status_type status,
   pqs_rsp_if.source               rsp_ch
);
   import pqs_pkg::*;

   localparam int CW   = $clog2(NUM_CLASSES);
   localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW   = $clog2(NUM_CLASSES * QUEUE_DEPTH);
   localparam int SLOTS = NUM_CLASSES * QUEUE_DEPTH;

   entry_type mem [SLOTS];

   logic [1:0]  req_cmd_ff;
   logic [15:0] req_id_ff, req_pat_ff, req_dur_ff;
   logic [1:0]  req_cls_ff;

   logic [HW-1:0]   head_ff [NUM_CLASSES];
   logic [CNTW-1:0] cnt_ff [NUM_CLASSES];
   logic            srv_busy_ff;
   logic [15:0]     srv_rem_ff, srv_id_ff;
   logic [CW-1:0]   srv_cls_ff;

   logic [CW-1:0]   cls_ff;
   logic [CNTW-1:0] k_ff, kept_ff;
   entry_type       rd_ff;

   logic            pend_valid_ff;
   event_type       pend_ev_ff;
   logic [15:0]     pend_id_ff;
   logic [1:0]      pend_cls_ff;

   logic            rsp_valid_ff;
   logic [2:0]      rsp_ev_ff;
   logic [15:0]     rsp_id_ff;
   logic [1:0]      rsp_cls_ff;
   logic            rsp_last_ff;

   function automatic logic [AW-1:0] slot_addr(logic [CW-1:0] c, logic [HW-1:0] h,
                                               logic [CNTW-1:0] off);
      logic [CNTW:0] sum;
      sum = (CNTW+1)'(h) + (CNTW+1)'(off);
      if (sum >= (CNTW+1)'(QUEUE_DEPTH)) sum = sum - (CNTW+1)'(QUEUE_DEPTH);
      return AW'(c) * AW'(QUEUE_DEPTH) + AW'(sum);
   endfunction

   logic            arr_ok, cls_ok;
   logic [CW-1:0]   arr_idx;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic            wr_en;
   entry_type       wr_data;
   logic [15:0]     rem_next;
   logic            out_free;
   logic            emit_en;
   event_type       emit_ev;
   logic [15:0]     emit_id;
   logic [1:0]      emit_cls;
   logic [CW-1:0]   pick_cls;
   logic            any_ne;

   assign cls_ok   = 32'(req_cls_ff) < NUM_CLASSES;
   assign arr_idx  = cls_ok ? CW'(req_cls_ff) : '0;
   assign arr_ok   = cls_ok && (cnt_ff[arr_idx] < CNTW'(QUEUE_DEPTH));
   assign rem_next = (srv_rem_ff != 16'd0) ? srv_rem_ff - 16'd1 : srv_rem_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rd_addr  = slot_addr(cls_ff, head_ff[cls_ff], k_ff);

   // lowest-numbered non-empty class
   always_comb begin
      pick_cls = '0;
      any_ne   = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (cnt_ff[c] != '0) begin
            pick_cls = CW'(c);
            any_ne   = 1'b1;
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_addr(cls_ff, head_ff[cls_ff], kept_ff);
      wr_data = rd_ff;
      if (cmd.keep) begin
         wr_en = 1'b1;
      end else if (cmd.age_wr) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr;
         wr_data.patience = (rd_ff.patience != 16'd0) ? rd_ff.patience - 16'd1 : 16'd0;
      end else if (cmd.arrive) begin
         wr_en   = arr_ok;
         wr_addr = slot_addr(arr_idx, head_ff[arr_idx], cnt_ff[arr_idx]);
         wr_data = '{id: req_id_ff, patience: req_pat_ff,
                     duration: (req_dur_ff == 16'd0) ? 16'd1 : req_dur_ff};
      end
   end

   always_comb begin
      emit_en  = 1'b0;
      emit_ev  = EV_HANG_UP;
      emit_id  = rd_ff.id;
      emit_cls = 2'(cls_ff);
      if (cmd.srv_tick) begin
         emit_en  = srv_busy_ff && (rem_next == 16'd0);
         emit_ev  = EV_COMPLETED;
         emit_id  = srv_id_ff;
         emit_cls = 2'(srv_cls_ff);
      end else if (cmd.drop) begin
         emit_en = 1'b1;
      end else if (cmd.answer) begin
         emit_en = 1'b1;
         emit_ev = EV_ANSWERED;
      end else if (cmd.arrive) begin
         emit_en  = 1'b1;
         emit_ev  = arr_ok ? EV_ACCEPTED : EV_REJECTED;
         emit_id  = req_id_ff;
         emit_cls = req_cls_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_cmd_ff <= req_command;
         req_id_ff  <= req_caller_id;
         req_cls_ff <= req_priority_class;
         req_pat_ff <= req_patience;
         req_dur_ff <= req_service_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
            cnt_ff[c]  <= '0;
         end
         srv_busy_ff <= 1'b0;
         srv_rem_ff  <= '0;
         srv_id_ff   <= '0;
         srv_cls_ff  <= '0;
         cls_ff      <= '0;
         k_ff        <= '0;
         kept_ff     <= '0;
      end else begin
         if (cmd.srv_tick) begin
            if (srv_busy_ff) begin
               srv_rem_ff <= rem_next;
               if (rem_next == 16'd0) srv_busy_ff <= 1'b0;
            end
            cls_ff  <= '0;
            k_ff    <= '0;
            kept_ff <= '0;
         end
         if (cmd.keep) begin
            k_ff    <= k_ff + 1'b1;
            kept_ff <= kept_ff + 1'b1;
         end
         if (cmd.drop || cmd.age_wr) k_ff <= k_ff + 1'b1;
         if (cmd.cls_end) begin
            cnt_ff[cls_ff] <= kept_ff;
            if (cls_ff != CW'(NUM_CLASSES - 1)) cls_ff <= cls_ff + 1'b1;
            k_ff    <= '0;
            kept_ff <= '0;
         end
         if (cmd.age_next) begin
            cls_ff <= cls_ff + 1'b1;
            k_ff   <= '0;
         end
         if (cmd.age_start) begin
            cls_ff <= '0;
            k_ff   <= '0;
         end
         if (cmd.pick) begin
            cls_ff <= pick_cls;
            k_ff   <= '0;
         end
         if (cmd.answer) begin
            head_ff[cls_ff] <= (32'(head_ff[cls_ff]) == QUEUE_DEPTH - 1) ? '0
                               : head_ff[cls_ff] + 1'b1;
            cnt_ff[cls_ff]  <= cnt_ff[cls_ff] - 1'b1;
            srv_busy_ff     <= 1'b1;
            srv_rem_ff      <= rd_ff.duration;
            srv_id_ff       <= rd_ff.id;
            srv_cls_ff      <= cls_ff;
            cls_ff          <= '0;
            k_ff            <= '0;
         end
         if (cmd.arrive && arr_ok) cnt_ff[arr_idx] <= cnt_ff[arr_idx] + 1'b1;
      end
   end

   // one event is held back so the final one of an item can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (emit_en) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) rsp_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
            rsp_valid_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         pend_ev_ff  <= emit_ev;
         pend_id_ff  <= emit_id;
         pend_cls_ff <= emit_cls;
      end
      if ((emit_en && pend_valid_ff) || cmd.flush) begin
         rsp_ev_ff   <= pend_ev_ff;
         rsp_id_ff   <= pend_id_ff;
         rsp_cls_ff  <= pend_cls_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_res   = rsp_ev_ff;
   assign rsp_ch.event_id    = rsp_id_ff;
   assign rsp_ch.event_class = rsp_cls_ff;
   assign rsp_ch.last        = rsp_last_ff;

   assign status.cmd          = req_cmd_ff;
   assign status.busy         = srv_busy_ff;
   assign status.any_nonempty = any_ne;
   assign status.k_done       = (k_ff == cnt_ff[cls_ff]);
   assign status.last_cls     = (cls_ff == CW'(NUM_CLASSES - 1));
   assign status.pat_zero     = (rd_ff.patience == 16'd0);
   assign status.emit_ok      = !pend_valid_ff || out_free;
   assign status.out_free     = out_free;
   assign status.pend_valid   = pend_valid_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[cls_ff] <= CNTW'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_busy_rem: assert property (@(posedge clock) disable iff (reset)
      srv_busy_ff |-> srv_rem_ff != 16'd0)
      else $error("busy server with no time left");
   a_kept: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= k_ff)
      else $error("compaction ahead of scan");

endmodule

>>> src/priority_queue_server_with_timeout.sv
// top level: strict priority queue server with deadline drop
// depends on pqs_pkg, pqs_if, pqs_ctrl, pqs_dp
//
//   channel   dir  handshake     payload
//   req_ch    in   valid/ready   command, caller_id, priority_class, patience, service_ticks
//   rsp_ch    out  valid/ready   event_res, event_id, event_class, last
//
// one item at a time; arrive passes decode, then writes the entry and its event, then closes in flush
// begin_tick counts down the server, then reads and checks each queued entry class by class, then flushes
// end_tick answers the head of the lowest-numbered non-empty class when the server is idle,
// then ages every queued entry class by class, then flushes
// results leave through one output register; a stalled output holds the walk
// synchronous reset clears heads, counts and the server; entries need no clearing
module priority_queue_server_with_timeout #(
   parameter int QUEUE_DEPTH = pqs_pkg::QUEUE_DEPTH_DEF,
   parameter int NUM_CLASSES = pqs_pkg::NUM_CLASSES_DEF
) (
   input logic       clock,
   input logic       reset,
   pqs_req_if.sink   req_ch,
   pqs_rsp_if.source rsp_ch
);
   import pqs_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           ready;

   pqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   pqs_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_ch.command),
      .req_caller_id      (req_ch.caller_id),
      .req_priority_class (req_ch.priority_class),
      .req_patience       (req_ch.patience),
      .req_service_ticks  (req_ch.service_ticks),
      .cmd                (cmd),
      .status             (status),
      .rsp_ch             (rsp_ch)
   );

   assign req_ch.ready = ready;

endmodule

>>> test/testbench.sv
// testbench for the strict priority queue server with deadline drop
// depends on pqs_pkg, pqs_if and priority_queue_server_with_timeout
`timescale 1ns / 100ps

module testbench;
   import pqs_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int CLASSES = NUM_CLASSES_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 200;
   // command code with no meaning, ignored by the block
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   typedef struct {
      event_type   res;
      logic [15:0] id;
      logic [1:0]  cls;
      logic        last;
   } call_event_type;

   logic clock;
   logic reset;
   pqs_req_if req_ch ();
   pqs_rsp_if rsp_ch ();

   priority_queue_server_with_timeout dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // predicted queue and server state
   logic [15:0] line_id  [CLASSES][DEPTH];
   logic [15:0] line_pat [CLASSES][DEPTH];
   logic [15:0] line_dur [CLASSES][DEPTH];
   int          line_head [CLASSES];
   int          line_count [CLASSES];
   logic        agent_busy;
   logic [15:0] agent_left;
   logic [15:0] agent_id;
   logic [1:0]  agent_cls;

   call_event_type pending_events [$];
   int  error_count;
   int  cycle_count;
   bit  idling_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("priority_queue_server_with_timeout: mismatch");
         $finish;
      end
   end

   function automatic void note_event(event_type res, logic [15:0] id, logic [1:0] cls);
      call_event_type ev;
      ev.res = res;
      ev.id = id;
      ev.cls = cls;
      ev.last = 1'b0;
      pending_events.push_back(ev);
   endfunction

   function automatic void predict_calls(logic [1:0] cmd, logic [15:0] id, logic [1:0] cls,
                                         logic [15:0] pat, logic [15:0] dur);
      int start_size;
      int kept;
      int src;
      int dst;
      bit picked;
      start_size = pending_events.size();
      if (cmd == CMD_BEGIN_TICK) begin
         if (agent_busy) begin
            if (agent_left > 0) agent_left = agent_left - 1;
            if (agent_left == 0) begin
               agent_busy = 1'b0;
               note_event(EV_COMPLETED, agent_id, agent_cls);
            end
         end
         // drop expired callers, survivors compacted in order
         for (int c = 0; c < CLASSES; c++) begin
            kept = 0;
            for (int k = 0; k < line_count[c]; k++) begin
               src = (line_head[c] + k) % DEPTH;
               if (line_pat[c][src] == 0) begin
                  note_event(EV_HANG_UP, line_id[c][src], c[1:0]);
               end else begin
                  dst = (line_head[c] + kept) % DEPTH;
                  line_id[c][dst] = line_id[c][src];
                  line_pat[c][dst] = line_pat[c][src];
                  line_dur[c][dst] = line_dur[c][src];
                  kept++;
               end
            end
            line_count[c] = kept;
         end
      end else if (cmd == CMD_ARRIVE) begin
         if (cls < CLASSES && line_count[cls] < DEPTH) begin
            dst = (line_head[cls] + line_count[cls]) % DEPTH;
            line_id[cls][dst] = id;
            line_pat[cls][dst] = pat;
            line_dur[cls][dst] = (dur == 0) ? 16'd1 : dur;
            line_count[cls]++;
            note_event(EV_ACCEPTED, id, cls);
         end else begin
            note_event(EV_REJECTED, id, cls);
         end
      end else if (cmd == CMD_END_TICK) begin
         picked = 1'b0;
         if (!agent_busy) begin
            for (int c = 0; c < CLASSES; c++) begin
               if (!picked && line_count[c] != 0) begin
                  src = line_head[c];
                  line_head[c] = (line_head[c] + 1) % DEPTH;
                  line_count[c]--;
                  agent_busy = 1'b1;
                  agent_left = line_dur[c][src];
                  agent_id = line_id[c][src];
                  agent_cls = c[1:0];
                  note_event(EV_ANSWERED, line_id[c][src], c[1:0]);
                  picked = 1'b1;
               end
            end
         end
         for (int c = 0; c < CLASSES; c++) begin
            for (int k = 0; k < line_count[c]; k++) begin
               src = (line_head[c] + k) % DEPTH;
               if (line_pat[c][src] > 0) line_pat[c][src] = line_pat[c][src] - 1;
            end
         end
      end
      if (pending_events.size() > start_size)
         pending_events[pending_events.size() - 1].last = 1'b1;
   endfunction

   // one item through the request channel, driven at the falling edge
   task automatic send_call(logic [1:0] cmd, logic [15:0] id, logic [1:0] cls,
                            logic [15:0] pat, logic [15:0] dur);
      int gap;
      if (idling_on && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 16);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.command = cmd;
      req_ch.caller_id = id;
      req_ch.priority_class = cls;
      req_ch.patience = pat;
      req_ch.service_ticks = dur;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_calls(cmd, id, cls, pat, dur);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver stalls in bursts
   initial begin
      int span;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         span = $urandom_range(1, 16);
         rsp_ch.ready = !(idling_on && $urandom_range(0, 2) == 0);
         repeat (span - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      call_event_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_events.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected item: res %0d id %h class %0d last %b",
                        rsp_ch.event_res, rsp_ch.event_id, rsp_ch.event_class, rsp_ch.last);
         end else begin
            want = pending_events.pop_front();
            if (rsp_ch.event_res !== want.res || rsp_ch.event_id !== want.id ||
                rsp_ch.event_class !== want.cls || rsp_ch.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("expected res %0d id %h cls %0d last %b, got %0d %h %0d %b",
                           want.res, want.id, want.cls, want.last, rsp_ch.event_res,
                           rsp_ch.event_id, rsp_ch.event_class, rsp_ch.last);
            end
         end
      end
   end

   task automatic run_directed();
      send_call(CMD_BEGIN_TICK, 16'h1111, 2'd0, 16'd0, 16'd0);
      send_call(CMD_UNKNOWN, 16'h2222, 2'd1, 16'd5, 16'd5);
      send_call(CMD_END_TICK, 16'h3333, 2'd2, 16'd5, 16'd5);
      // a caller with zero patience hangs up before it can be answered
      send_call(CMD_ARRIVE, 16'hFFFF, 2'd3, 16'h0000, 16'hFFFF);
      send_call(CMD_ARRIVE, 16'h0000, 2'd0, 16'hFFFF, 16'h0000);
      send_call(CMD_BEGIN_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
      for (int i = 0; i < DEPTH + 1; i++)
         send_call(CMD_ARRIVE, 16'h0100 + i, 2'd1, 16'd20, 16'd2);
      send_call(CMD_END_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
      send_call(CMD_BEGIN_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
      send_call(CMD_END_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
      send_call(CMD_ARRIVE, 16'hA5A5, 2'd2, 16'd1, 16'd3);
      send_call(CMD_END_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
      send_call(CMD_BEGIN_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
      send_call(CMD_BEGIN_TICK, 16'h0, 2'd0, 16'd0, 16'd1);
   endtask

   task automatic random_call();
      int pick;
      logic [15:0] pat;
      logic [15:0] dur;
      pick = $urandom_range(0, 99);
      pat = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      dur = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      if (pick < 45)
         send_call(CMD_ARRIVE, 16'($urandom), 2'($urandom), pat, dur);
      else if (pick < 70)
         send_call(CMD_END_TICK, 16'($urandom), 2'($urandom), pat, dur);
      else if (pick < 95)
         send_call(CMD_BEGIN_TICK, 16'($urandom), 2'($urandom), pat, dur);
      else
         send_call(CMD_UNKNOWN, 16'($urandom), 2'($urandom), pat, dur);
   endtask

   task automatic run_random_traffic();
      repeat (150) random_call();
   endtask

   task automatic run_after_pause();
      // sender holds off until every item has come back
      wait_drained();
      repeat (100) random_call();
   endtask

   task automatic run_unstalled_tail();
      idling_on = 1'b0;
      repeat (60) random_call();
   endtask

   initial begin
      reset = 1'b1;
      idling_on = 1'b1;
      error_count = 0;
      cycle_count = 0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_BEGIN_TICK;
      req_ch.caller_id = '0;
      req_ch.priority_class = '0;
      req_ch.patience = '0;
      req_ch.service_ticks = '0;
      for (int c = 0; c < CLASSES; c++) begin
         line_head[c] = 0;
         line_count[c] = 0;
      end
      agent_busy = 1'b0;
      agent_left = '0;
      agent_id = '0;
      agent_cls = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_random_traffic();
      run_after_pause();
      run_unstalled_tail();
      wait_drained();
      if (error_count == 0) begin
         $display("priority_queue_server_with_timeout: match");
      end else begin
         $display("priority_queue_server_with_timeout: mismatch");
      end
      $finish;
   end

endmodule
